// ===== src/lpm6_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm6_pkg
// Shared types and helpers for the IPv6 longest-prefix-match route table.
// ----------------------------------------------------------------------------
package lpm6_pkg;

    localparam int unsigned ADDR_W  = 128;
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned CNT_W   = 7;
    localparam logic [LEN_W-1:0] LEN_MAX = 8'd128;

    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

    // One item in flight: destination/prefix plus the best match so far
    // (a write item carries its entry data in the best-match fields).
    typedef struct packed
    {
        logic              valid;
        cmd_t              cmd;
        logic [IDX_W-1:0]  index;
        logic [ADDR_W-1:0] addr;
        logic              found;
        logic [LEN_W-1:0]  len;
        logic              direct;
        logic [ADDR_W-1:0] gw;
        logic [ADDR_W-1:0] pfx;
    } stage_t;

    // Mask of the most significant len bits of an address.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int j = 0; j < ADDR_W; j++)
        begin
            m[ADDR_W-1-j] = (LEN_W'(j) < len);
        end
        return m;
    endfunction

endpackage

// ===== src/ipv6_longest_prefix_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_longest_prefix_match
// IPv6 route table searched linearly for the longest matching prefix.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream: tuser is the command, write or lookup.
// A write item stores one entry and gives no result; a lookup item gives
// one result item on the m_ stream, found in tuser.
// route_count is set through the APB port; the user must do this only while
// the block is idle, as the block itself does not enforce it. Each entry
// lives in its own stage of a chain of MAX_ROUTES cells; an item passes the
// input register and then one cell per cycle, so a write and a lookup keep
// their order. One item is taken every cycle while the receiver keeps up.
// When the result stage holds an item that is not taken, the whole chain
// holds and s_tready drops; nothing is lost or repeated.
// Reset clears route_count and the valid bits of the chain; table entries
// are undefined until written.
// ----------------------------------------------------------------------------
module ipv6_longest_prefix_match #(
    parameter int MAX_ROUTES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index, addr_hi, addr_lo, prefix_len, is_direct, gateway_hi, gateway_lo
    input  logic [271:0] s_tdata,
    // cmd
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // match_len, match_direct, match_gw_hi, match_gw_lo, match_prefix_hi, match_prefix_lo
    output logic [271:0] m_tdata,
    // found
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import lpm6_pkg::*;

    localparam logic [2:0] ADDR_ROUTE_COUNT = 3'd0;

    logic [CNT_W-1:0] count_reg;
    logic             in_valid_reg;
    stage_t           in_reg;
    stage_t           in_next;
    stage_t           chain [MAX_ROUTES+1];
    stage_t           last;
    logic             en;
    logic [LEN_W-1:0] plen;

    assign pready = 1'b1;
    assign prdata = {{(32-CNT_W){1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_ROUTE_COUNT))
        begin
            count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign last     = chain[MAX_ROUTES];
    assign m_tvalid = last.valid && (last.cmd == CMD_LOOKUP);
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign plen = s_tdata[141:134];

    always_comb
    begin
        in_next        = '0;
        in_next.valid  = s_tvalid;
        in_next.cmd    = cmd_t'(s_tuser[0]);
        in_next.index  = s_tdata[5:0];
        in_next.addr   = {s_tdata[69:6], s_tdata[133:70]};
        if (in_next.cmd == CMD_WRITE)
        begin
            in_next.len    = (plen > LEN_MAX) ? LEN_MAX : plen;
            in_next.direct = s_tdata[142];
            in_next.gw     = {s_tdata[206:143], s_tdata[270:207]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg <= in_next;
        end
    end

    always_comb
    begin
        chain[0]       = in_reg;
        chain[0].valid = in_valid_reg;
    end

    for (genvar k = 0; k < MAX_ROUTES; k++)
    begin : g_cell
        lpm6_cell #(
            .INDEX (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (en),
            .route_count (count_reg),
            .din         (chain[k]),
            .dout        (chain[k+1])
        );
    end

    assign m_tuser = last.found;
    assign m_tdata = {7'b0, last.pfx[63:0], last.pfx[127:64], last.gw[63:0],
                      last.gw[127:64], last.direct, last.len};

endmodule

// ===== src/lpm6_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm6_cell
// One route entry and one pipeline stage: store the entry on a write item,
// compare and update the best match on a lookup item.
// ----------------------------------------------------------------------------
module lpm6_cell #(
    parameter int INDEX = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [lpm6_pkg::CNT_W-1:0]  route_count,
    input  lpm6_pkg::stage_t            din,
    output lpm6_pkg::stage_t            dout
);
    import lpm6_pkg::*;

    logic [ADDR_W-1:0] pfx_reg;
    logic [ADDR_W-1:0] mask_reg;
    logic [ADDR_W-1:0] gw_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              dir_reg;
    logic              valid_reg;
    stage_t            data_reg;
    stage_t            data_next;
    logic              wr;
    logic              hit;

    assign wr = din.valid && (din.cmd == CMD_WRITE) && (int'(din.index) == INDEX);

    assign hit = (din.cmd == CMD_LOOKUP) && (int'(route_count) > INDEX)
                 && (((din.addr ^ pfx_reg) & mask_reg) == '0)
                 && (!din.found || (len_reg > din.len));

    always_comb
    begin
        data_next = din;
        if (hit)
        begin
            data_next.found  = 1'b1;
            data_next.len    = len_reg;
            data_next.direct = dir_reg;
            data_next.gw     = gw_reg;
            data_next.pfx    = pfx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && wr)
        begin
            pfx_reg  <= din.addr;
            mask_reg <= prefix_mask(din.len);
            len_reg  <= din.len;
            dir_reg  <= din.direct;
            gw_reg   <= din.gw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        dout       = data_reg;
        dout.valid = valid_reg;
    end

endmodule

// ===== src/lpm6_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm6_checker
// Port-level checks on the route table, bound to the top level.
// ----------------------------------------------------------------------------
module lpm6_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [271:0] m_tdata,
    input logic [0:0]   m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss result carries data");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[7:0] <= 8'd128)
        else $error("match length beyond 128");

endmodule

bind ipv6_longest_prefix_match lpm6_checker u_lpm6_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/ipv6_longest_prefix_match_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_longest_prefix_match_tb
// Self-checking bench for the IPv6 longest-prefix-match route table.
// Table writes and lookups are streamed in under varied idle and stall
// patterns; a software copy of the table predicts each lookup result and
// every result item is compared field by field. route_count is changed over
// APB between phases, once the block has drained.
// ----------------------------------------------------------------------------
module ipv6_longest_prefix_match_tb;

    import lpm6_pkg::*;

    localparam logic [2:0] REG_ROUTE_COUNT = 3'd0;
    localparam int         ROUTES          = 64;
    localparam int         DRAIN_CYCLES    = 80;
    localparam int         WATCHDOG_LIMIT  = 20000;

    typedef struct {
        logic         found;
        logic [7:0]   len;
        logic         direct;
        logic [127:0] gw;
        logic [127:0] pfx;
    } route_hit_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [271:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [271:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    logic [127:0] tbl_pfx [ROUTES];
    logic [127:0] tbl_gw  [ROUTES];
    logic [7:0]   tbl_len [ROUTES];
    logic         tbl_dir [ROUTES];
    logic [6:0]   route_count;

    route_hit_t   pending_hits[$];
    int           errors;
    int           send_idle_pct;
    int           recv_stall_pct;
    bit           hold_req;
    int           hold_left;
    int           quiet_cycles;
    logic [127:0] bases [4];

    ipv6_longest_prefix_match uut (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [127:0] pfx_mask(input logic [7:0] len);
        if (len == 8'd0)
            return '0;
        return {128{1'b1}} << (128 - len);
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic route_hit_t best_route(input logic [127:0] dest);
        route_hit_t r;
        int         n;
        logic [127:0] m;
        r = '{found: 1'b0, len: 8'd0, direct: 1'b0, gw: '0, pfx: '0};
        n = (route_count > ROUTES) ? ROUTES : route_count;
        for (int i = 0; i < n; i++)
        begin
            m = pfx_mask(tbl_len[i]);
            if ((dest & m) == (tbl_pfx[i] & m) && (!r.found || tbl_len[i] > r.len))
            begin
                r = '{found: 1'b1, len: tbl_len[i], direct: tbl_dir[i],
                      gw: tbl_gw[i], pfx: tbl_pfx[i]};
            end
        end
        return r;
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 300;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        route_hit_t e;
        if (m_tvalid && m_tready)
        begin
            if (pending_hits.size() == 0)
            begin
                $display("%0t: result item with nothing expected, got %h/%h",
                         $realtime, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                e = pending_hits.pop_front();
                if (m_tuser[0] !== e.found)
                begin
                    $display("%0t: found exp %0b got %0b", $realtime, e.found, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[7:0] !== e.len)
                begin
                    $display("%0t: match_len exp %0d got %0d", $realtime, e.len, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[8] !== e.direct)
                begin
                    $display("%0t: match_direct exp %0b got %0b", $realtime, e.direct,
                             m_tdata[8]);
                    errors++;
                end
                if ({m_tdata[72:9], m_tdata[136:73]} !== e.gw)
                begin
                    $display("%0t: match_gw exp %h got %h", $realtime, e.gw,
                             {m_tdata[72:9], m_tdata[136:73]});
                    errors++;
                end
                if ({m_tdata[200:137], m_tdata[264:201]} !== e.pfx)
                begin
                    $display("%0t: match_prefix exp %h got %h", $realtime, e.pfx,
                             {m_tdata[200:137], m_tdata[264:201]});
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[ipv6_longest_prefix_match] ERROR");
            $finish;
        end
    end

    task automatic send_item(input cmd_t cmd, input logic [5:0] idx, input logic [127:0] addr,
                             input logic [7:0] len, input logic dir, input logic [127:0] gw);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, gw[63:0], gw[127:64], dir, len, addr[63:0], addr[127:64], idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd == CMD_WRITE)
        begin
            tbl_pfx[idx] = addr;
            tbl_len[idx] = (len > LEN_MAX) ? LEN_MAX : len;
            tbl_dir[idx] = dir;
            tbl_gw[idx]  = gw;
        end
        else
            pending_hits.push_back(best_route(addr));
    endtask

    task automatic lookup(input logic [127:0] dest);
        send_item(CMD_LOOKUP, 6'($urandom), dest, 8'($urandom), 1'($urandom), rand128());
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_route_count(input logic [31:0] value);
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_ROUTE_COUNT;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        route_count = value[6:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Prefix near one of the four bases, so that routes nest and overlap, or at times fully random.
    task automatic write_random(input logic [5:0] idx);
        logic [7:0]   len;
        logic [127:0] p;
        len = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(128));
        p   = (bases[$urandom_range(3)] & pfx_mask(len)) | (rand128() & ~pfx_mask(len));
        if ($urandom_range(9) == 0)
            p = rand128();
        send_item(CMD_WRITE, idx, p, len, 1'($urandom), rand128());
    endtask

    task automatic lookup_random();
        int k;
        logic [127:0] m;
        k = $urandom_range(ROUTES - 1);
        m = pfx_mask(tbl_len[k]);
        if ($urandom_range(9) == 0)
            lookup(rand128());
        else
            lookup((tbl_pfx[k] & m) | (rand128() & ~m));
    endtask

    task automatic test_empty_and_fill();
        lookup('0);
        lookup({128{1'b1}});
        for (int i = 0; i < ROUTES; i++)
            write_random(6'(i));
    endtask

    task automatic test_directed();
        logic [127:0] a;
        a = bases[0];
        set_route_count(ROUTES);
        send_item(CMD_WRITE, 6'd0, '0, 8'd0, 1'b1, {128{1'b1}});
        send_item(CMD_WRITE, 6'd1, a, 8'd128, 1'b0, rand128());
        send_item(CMD_WRITE, 6'd2, a ^ 128'd1, 8'd255, 1'b1, rand128());
        send_item(CMD_WRITE, 6'd3, a, 8'd64, 1'b0, rand128());
        send_item(CMD_WRITE, 6'd4, a ^ {64'd0, 64'h8000_0000_0000_0000}, 8'd65, 1'b1,
                  rand128());
        send_item(CMD_WRITE, 6'd5, a, 8'd64, 1'b1, rand128());
        send_item(CMD_WRITE, 6'd6, {128{1'b1}}, 8'd1, 1'b0, '0);
        lookup(a);
        lookup(a ^ 128'd1);
        lookup(a ^ 128'd2);
        lookup(a ^ {64'd0, 64'h8000_0000_0000_0000});
        lookup(a ^ {64'd1, 64'd0});
        lookup({128{1'b1}});
        lookup('0);
        set_route_count(127);
        lookup(a);
        lookup(rand128());
        set_route_count(1);
        lookup(a);
        lookup(rand128());
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int items);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        set_route_count(($urandom_range(3) == 0) ? ROUTES : $urandom_range(ROUTES));
        for (int i = 0; i < items; i++)
        begin
            if ($urandom_range(9) == 0)
                write_random(6'($urandom));
            else
                lookup_random();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_route_count(ROUTES);
        hold_req = 1'b1;
        for (int i = 0; i < 150; i++)
            lookup_random();
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        hold_left = 0;
        quiet_cycles = 0;
        route_count = '0;
        for (int i = 0; i < 4; i++)
            bases[i] = rand128();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_and_fill();
        test_directed();
        test_random_phase(0, 0, 220);
        test_random_phase(61, 0, 220);
        test_random_phase(0, 61, 220);
        test_random_phase(15, 15, 220);
        test_backpressure();
        test_random_phase(0, 0, 100);
        drain();

        if (errors == 0)
            $display("[ipv6_longest_prefix_match] OK");
        else
            $display("[ipv6_longest_prefix_match] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/lpm6_pkg.sv
src/lpm6_cell.sv
src/ipv6_longest_prefix_match.sv
src/lpm6_checker.sv
tb/sv/ipv6_longest_prefix_match_tb.sv
